FILE: design/ipt_pkg.sv
// Shared constants and types for the integer pseudonym table.
`default_nettype none

package ipt_pkg;

    localparam int ENTRY_COUNT = 64;
    localparam int IDX_W       = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
    localparam int CNT_W       = $clog2(ENTRY_COUNT + 1);

    localparam int VAL_W  = 64;
    localparam int REM_W  = 20;      // holds 0 .. SURR_MOD-1
    localparam int SURR_W = 22;      // signed surrogate, -799999 .. 899999

    // remainder unit: one dividend byte per digit, an estimate step then a subtract step
    localparam int CHUNK_W   = 8;
    localparam int CHUNKS    = VAL_W / CHUNK_W;
    localparam int STEP_W    = $clog2(2 * CHUNKS + 1);
    localparam int QUO_W     = CHUNK_W;
    localparam int PART_W    = REM_W + CHUNK_W;      // remainder with next byte
    localparam int MOD_LOW_W = 5;                    // 900000 = 2^5 * 28125
    localparam int REC_IN_W  = PART_W - MOD_LOW_W;
    localparam int REC_MUL_W = 24;
    localparam int REC_P_W   = REC_IN_W + REC_MUL_W;
    localparam int REC_SHIFT = 38;

    localparam logic [VAL_W-1:0]     XOR_KEY    = 64'h0000_0005_DEEC_E66D;
    localparam logic [REM_W:0]       SURR_MOD   = 21'd900000;
    localparam logic [REM_W-1:0]     SURR_FLOOR = 20'd100000;
    // ceil(2^38 / 28125); exact quotient for any partial dividend below 2^28
    localparam logic [REC_MUL_W-1:0] REC_MUL    = 24'd9773437;

    typedef enum logic [1:0] {
        OUT_FOUND  = 2'd0,
        OUT_INSERT = 2'd1,
        OUT_FULL   = 2'd2
    } t_outcome;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_FIN  = 3'b100
    } t_state;

endpackage

`default_nettype wire

FILE: design/ipt_rem.sv
// Signed remainder by 900000, a byte at a time by reciprocal multiply, and surrogate fix-up.
`default_nettype none

module ipt_rem (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [ipt_pkg::VAL_W-1:0] i_value,
    output logic                           o_idle,
    output logic [ipt_pkg::VAL_W-1:0]      o_surr
);
    import ipt_pkg::*;

    logic [VAL_W-1:0]   r_mag;
    logic [REM_W-1:0]   r_rem;
    logic [QUO_W-1:0]   r_quo;
    logic [STEP_W-1:0]  r_cnt;
    logic               r_neg;
    logic               r_busy;

    logic [VAL_W-1:0]   w_u;
    logic [PART_W-1:0]  w_part;
    logic [REC_P_W-1:0] w_prod;
    logic [PART_W-1:0]  w_back;
    logic [SURR_W-1:0]  w_surr;

    assign w_u    = i_value ^ XOR_KEY;
    // running remainder with the next dividend byte appended
    assign w_part = {r_rem, r_mag[VAL_W-1 -: CHUNK_W]};
    // quotient digit: drop the 2^5 factor, then multiply by 1/28125
    assign w_prod = REC_P_W'(w_part[PART_W-1:MOD_LOW_W]) * REC_P_W'(REC_MUL);
    assign w_back = PART_W'(r_quo) * PART_W'(SURR_MOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= STEP_W'(2 * CHUNKS);
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_busy <= (r_cnt != STEP_W'(1));
        end
    end

    // even count: estimate the digit; odd count: subtract and take next byte
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= w_u[VAL_W-1];
            r_mag <= w_u[VAL_W-1] ? (~w_u + 1'b1) : w_u;
            r_rem <= '0;
        end else if (r_busy) begin
            if (!r_cnt[0]) begin
                r_quo <= w_prod[REC_SHIFT +: QUO_W];
            end else begin
                r_rem <= REM_W'(w_part - w_back);
                r_mag <= {r_mag[VAL_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
            end
        end
    end

    // negative side: -rem is always below the floor, so floor is added
    always_comb begin
        if (r_neg) begin
            w_surr = {2'b00, SURR_FLOOR} - {2'b00, r_rem};
        end else if (r_rem < SURR_FLOOR) begin
            w_surr = {2'b00, r_rem} + {2'b00, SURR_FLOOR};
        end else begin
            w_surr = {2'b00, r_rem};
        end
    end

    assign o_idle = !r_busy;
    assign o_surr = {{(VAL_W-SURR_W){w_surr[SURR_W-1]}}, w_surr};

endmodule

`default_nettype wire

FILE: design/integer_pseudonym_table.sv
// Top level: value table with linear key scan and surrogate generation.
`default_nettype none

//  channel  | dir | word                                   | handshake
//  s_axis   | in  | tdata[63:0] original_value             | tvalid/tready
//  m_axis   | out | tdata[63:0] result_value, tuser[1:0] outcome | tvalid/tready
//
//  Each accepted word runs the key scan, which reads one stored key per cycle
//  until a hit or the end of the filled part, while the remainder unit runs
//  alongside, one dividend byte per digit; the result is registered and the
//  block returns to idle together, once both have finished.
//  Reset (synchronous, active low) empties the table through the fill count;
//  a result waiting on m_axis holds the block in its final step until taken.

module integer_pseudonym_table (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  wire logic [ipt_pkg::VAL_W-1:0] i_s_axis_tdata,  // [63:0] original_value
    output logic                           o_m_axis_tvalid,
    input  wire logic                      i_m_axis_tready,
    output logic [ipt_pkg::VAL_W-1:0]      o_m_axis_tdata,  // [63:0] result_value
    output logic [1:0]                     o_m_axis_tuser   // [1:0] outcome
);
    import ipt_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_issue;
    logic              r_pend;
    logic              r_found;
    logic [VAL_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_rdata;
    logic              r_out_valid;
    logic [VAL_W-1:0]  r_out_data;
    t_outcome          r_out_code;

    logic [VAL_W-1:0]  mem [ENTRY_COUNT];

    logic              w_accept;
    logic              w_hit;
    logic              w_scan_end;
    logic              w_rd_en;
    logic              w_out_free;
    logic              w_rem_idle;
    logic              w_finish;
    logic              w_full;
    logic              w_insert;
    logic [VAL_W-1:0]  w_surr;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_hit      = r_pend && (r_rdata == r_key);
    assign w_rd_en    = (r_state == ST_SCAN) && !w_hit && (r_issue < r_fill);
    assign w_scan_end = w_hit || (!r_pend && (r_issue >= r_fill));
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_finish   = (r_state == ST_FIN) && w_rem_idle && w_out_free;
    assign w_full     = (r_fill == CNT_W'(ENTRY_COUNT));
    assign w_insert   = w_finish && !r_found && !w_full;

    ipt_rem u_rem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_value (i_s_axis_tdata),
        .o_idle  (w_rem_idle),
        .o_surr  (w_surr)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_SCAN;
            end
            ST_SCAN: begin
                if (w_scan_end) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (w_finish) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_issue <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_issue <= '0;
                r_pend  <= 1'b0;
                r_found <= 1'b0;
            end else if (r_state == ST_SCAN) begin
                r_pend <= w_rd_en;
                if (w_rd_en) r_issue <= r_issue + 1'b1;
                if (w_hit)   r_found <= 1'b1;
            end
            if (w_insert) r_fill <= r_fill + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) r_key <= i_s_axis_tdata;
    end

    // key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_insert) mem[r_fill[IDX_W-1:0]] <= r_key;
        if (w_rd_en)  r_rdata <= mem[r_issue[IDX_W-1:0]];
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            priority if (r_found) begin
                r_out_data <= w_surr;
                r_out_code <= OUT_FOUND;
            end else if (w_full) begin
                r_out_data <= r_key;
                r_out_code <= OUT_FULL;
            end else begin
                r_out_data <= w_surr;
                r_out_code <= OUT_INSERT;
            end
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_code;

    // fill count never passes capacity
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(ENTRY_COUNT))
        else $error("fill count above capacity");

    // an insert grows the table by exactly one
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_insert |=> (r_fill == $past(r_fill) + 1'b1))
        else $error("fill count did not advance on insert");

    // a new key with room in the table is inserted, never passed through
    a_full_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_finish && !r_found && !w_full) |=> (r_out_code == OUT_INSERT))
        else $error("new key with room not inserted");

    // scan never reads past the filled part of the table
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rd_en |-> (r_issue < r_fill))
        else $error("scan read beyond fill count");

endmodule

`default_nettype wire

FILE: verif/integer_pseudonym_table_test.sv
// Self-checking stream testbench for the integer pseudonym table.
`default_nettype none

module integer_pseudonym_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    import ipt_pkg::*;

    // Cycles without any handshake before the run is declared hung; this is
    // well above the slowest word, the longest sender gap and the longest
    // receiver stall put together.
    localparam int HANG_LIMIT    = 3000;
    // Quiet cycles after the last result.
    localparam int DRAIN_CYCLES  = 100;
    localparam int RANDOM_WORDS  = 700;
    localparam longint PSEUDO_FLOOR = longint'(SURR_FLOOR);

    // ---------------------------------------------------------------- DUT I/O
    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    logic [VAL_W-1:0]   i_s_axis_tdata  = '0;   // [63:0] original_value
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    logic [VAL_W-1:0]   o_m_axis_tdata;         // [63:0] result_value
    logic [1:0]         o_m_axis_tuser;         // [1:0] outcome

    integer_pseudonym_table DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // ---------------------------------------------------------- shared state
    // Words waiting to be sent; a set hold flag makes the sender wait until
    // every outstanding result has come back before offering that word.
    bit [VAL_W-1:0] pending_words[$];
    bit             pending_hold[$];
    // Every value queued so far, used to draw repeats.
    bit [VAL_W-1:0] sent_values[$];

    // Expected results, oldest first.
    bit [VAL_W-1:0] expected_values[$];
    t_outcome       expected_outcomes[$];

    // Testbench copy of the value table.
    bit [VAL_W-1:0] table_keys[ENTRY_COUNT];
    int             table_fill = 0;

    int  error_count = 0;
    int  hang_count  = 0;
    bit  sender_busy = 1'b0;

    // --------------------------------------------------------------- predictor
    // XOR with the fixed key, signed truncating remainder, lift below floor.
    function automatic bit [VAL_W-1:0] pseudonym_of(input bit [VAL_W-1:0] value);
        bit [VAL_W-1:0] mixed;
        bit [VAL_W-1:0] mag;
        longint         rem;
        mixed = value ^ XOR_KEY;
        if (mixed[VAL_W-1]) begin
            mag = ~mixed + 64'd1;          // 2^63 stays correct as unsigned
            rem = -longint'(mag % SURR_MOD);
        end else begin
            rem = longint'(mixed % SURR_MOD);
        end
        if (rem < PSEUDO_FLOOR) begin
            rem = rem + PSEUDO_FLOOR;      // negative remainders stay negative below -100000
        end
        return rem;
    endfunction

    // Look the value up, insert it if there is room, queue the expected result.
    task automatic lookup_and_record(input bit [VAL_W-1:0] value);
        bit hit;
        hit = 1'b0;
        for (int k = 0; k < table_fill; k++) begin
            if (table_keys[k] == value) begin
                hit = 1'b1;
            end
        end
        if (hit) begin
            expected_values.push_back(pseudonym_of(value));
            expected_outcomes.push_back(OUT_FOUND);
        end else if (table_fill >= ENTRY_COUNT) begin
            expected_values.push_back(value);
            expected_outcomes.push_back(OUT_FULL);
        end else begin
            table_keys[table_fill] = value;
            table_fill = table_fill + 1;
            expected_values.push_back(pseudonym_of(value));
            expected_outcomes.push_back(OUT_INSERT);
        end
    endtask

    task automatic add_word(input bit [VAL_W-1:0] value, input bit hold);
        pending_words.push_back(value);
        pending_hold.push_back(hold);
        sent_values.push_back(value);
    endtask

    // ------------------------------------------------------------------ driver
    // Bursts of random length separated by random gaps; the gap counter runs
    // from the last accepted word so offers land on every phase of the scan.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge i_clk) begin : sender
        bit launch;
        launch = 1'b0;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                lookup_and_record(i_s_axis_tdata);
                burst_left = burst_left - 1;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
                end
            end
            if (i_s_axis_tvalid && !o_s_axis_tready) begin
                launch = 1'b1;                     // hold the offered word
            end else if (gap_left > 0) begin
                gap_left = gap_left - 1;
            end else if (pending_words.size() > 0 &&
                         (!pending_hold[0] || expected_values.size() == 0)) begin
                launch = 1'b1;
                i_s_axis_tdata <= pending_words.pop_front();
                void'(pending_hold.pop_front());
            end
            i_s_axis_tvalid <= launch;
        end
        sender_busy = launch || pending_words.size() > 0;
    end

    // --------------------------------------------------------- receiver stall
    // Ready pattern, redrawn at random: always ready, coin toss, or a long
    // periodic stall in which ready is low for most of each period.
    int stall_mode = 0;
    int stall_tick = 0;

    always @(posedge i_clk) begin : receiver_ready
        if (stall_tick % 300 == 0) begin
            stall_mode = $urandom_range(0, 2);
        end
        stall_tick = stall_tick + 1;
        case (stall_mode)
            0: begin
                i_m_axis_tready <= 1'b1;
            end
            1: begin
                i_m_axis_tready <= 1'($urandom_range(0, 1));
            end
            default: begin
                i_m_axis_tready <= (stall_tick % 37) >= 25;
            end
        endcase
    end

    // ----------------------------------------------------------------- monitor
    always @(posedge i_clk) begin : result_check
        bit [VAL_W-1:0] want_value;
        t_outcome       want_outcome;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (expected_values.size() == 0) begin
                $error("unexpected result word: result_value %h outcome %0d",
                       o_m_axis_tdata, o_m_axis_tuser);
                error_count = error_count + 1;
            end else begin
                want_value   = expected_values.pop_front();
                want_outcome = expected_outcomes.pop_front();
                if (o_m_axis_tdata !== want_value) begin
                    $error("result_value: expected %h, got %h", want_value, o_m_axis_tdata);
                    error_count = error_count + 1;
                end
                if (o_m_axis_tuser !== want_outcome) begin
                    $error("outcome: expected %0d, got %0d", want_outcome, o_m_axis_tuser);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // ---------------------------------------------------------------- watchdog
    always @(posedge i_clk) begin : hang_watch
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            hang_count = 0;
        end else begin
            hang_count = hang_count + 1;
        end
        if (hang_count >= HANG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // --------------------------------------------------------------- stimulus
    initial begin : stimulus
        bit [VAL_W-1:0] value;
        bit [VAL_W-1:0] delta;
        int             pick;

        // Directed: field extremes, surrogate floor edges, negative
        // remainders on both sides of -100000, and repeats of stored keys.
        add_word(64'd0, 1'b0);
        add_word(64'd1, 1'b0);
        add_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_word(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        add_word(64'h8000_0000_0000_0000, 1'b0);
        add_word(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
        add_word(64'h5555_5555_5555_5555, 1'b0);
        add_word(XOR_KEY, 1'b0);                           // remainder zero
        add_word(XOR_KEY ^ 64'd99999, 1'b0);               // just below floor
        add_word(XOR_KEY ^ 64'd100000, 1'b0);              // exactly at floor
        add_word(XOR_KEY ^ 64'd899999, 1'b0);              // largest remainder
        add_word(XOR_KEY ^ 64'd900000, 1'b0);              // wraps to zero
        add_word(~XOR_KEY, 1'b0);                          // mixed value -1
        add_word(XOR_KEY ^ (64'd0 - 64'd100000), 1'b0);    // lifts to zero
        add_word(XOR_KEY ^ (64'd0 - 64'd500000), 1'b0);    // stays negative
        add_word(XOR_KEY ^ (64'd0 - 64'd899999), 1'b0);    // most negative
        add_word(64'd0, 1'b1);                             // found, after drain
        add_word(64'h8000_0000_0000_0000, 1'b0);
        add_word(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        add_word(XOR_KEY ^ (64'd0 - 64'd500000), 1'b0);

        // Random: repeats of earlier values, values near the key so the
        // remainder sweeps its range, and full-width noise. The table fills
        // early, after which new values take the passthrough path.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                value = sent_values[$urandom_range(0, sent_values.size() - 1)];
            end else if (pick < 55) begin
                delta = 64'($urandom_range(0, 1999999));
                value = XOR_KEY ^ (delta - 64'd1000000);
            end else begin
                value = {$urandom, $urandom};
            end
            add_word(value, (n % 175) == 174);
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every word is accepted and every result has come back.
        @(posedge i_clk);
        while (sender_busy || i_s_axis_tvalid || expected_values.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
design/ipt_pkg.sv
design/ipt_rem.sv
design/integer_pseudonym_table.sv
verif/integer_pseudonym_table_test.sv
